@@ src/fsdc_pkg.sv @@
// Shared types and constants of the fan speed deadband controller.
// No dependencies; the csr, core, top level and testbench import this package.
package fsdc_pkg;

   localparam logic [7:0]        MAX_FAN_SPEED = 8'd50;
   localparam logic signed [7:0] PERSIST_TRIP  = 8'sd12;

   // floor(x/5) for x < 1024 is (x*205) >> 10
   localparam logic [7:0] DIV5_RECIP = 8'd205;
   localparam int         DIV5_SHIFT = 10;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_INIT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_TARGET_TEMP  = 2'd0,
      REG_MIN_FAN      = 2'd1,
      REG_BOARD_SCALED = 2'd2,
      REG_REFRESH      = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [7:0] target_temp;
      logic [5:0] min_fan_speed;
      logic       board_scaled_mode;
      logic [5:0] refresh_period;
   } cfg_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] proc_temp;
      logic [7:0] board_temp;
      logic [7:0] fan_sense;
   } req_type;

   typedef struct packed {
      logic       fan_write;
      logic [7:0] fan_speed;
      logic       evaluated;
   } rsp_type;

endpackage

@@ src/fsdc_req_if.sv @@
// Input channel of the fan controller: valid/ready plus one sensor item.
// Depends on nothing.
interface fsdc_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] proc_temp;
   logic [7:0] board_temp;
   logic [7:0] fan_sense;

   modport source (output valid, op, proc_temp, board_temp, fan_sense, input ready);
   modport sink   (input valid, op, proc_temp, board_temp, fan_sense, output ready);
endinterface

@@ src/fsdc_rsp_if.sv @@
// Result channel of the fan controller: valid/ready plus one result item.
// Depends on nothing.
interface fsdc_rsp_if;
   logic       valid;
   logic       ready;
   logic       fan_write;
   logic [7:0] fan_speed;
   logic       evaluated;

   modport source (output valid, fan_write, fan_speed, evaluated, input ready);
   modport sink   (input valid, fan_write, fan_speed, evaluated, output ready);
endinterface

@@ src/fan_speed_deadband_controller_unit.sv @@
// Top level of the fan speed deadband controller: input register, core, result register.
// Depends on fsdc_pkg, fsdc_req_if, fsdc_rsp_if, fsdc_csr and fsdc_core.
//
// Usage:
//   req_ch carries one item per tick: op (tick or init), CPU and board
//   temperatures and the fan readback. rsp_ch returns exactly one result
//   item per input item, in order: fan_write, fan_speed, evaluated.
//   Both channels move an item when valid and ready are high at a clock edge.
//   An accepted item sits in the input register while the decision logic
//   updates the controller state; it moves into the result register, and
//   the controller state is written, once the result register is empty or
//   its item is being taken.
//   Throughput is one item per cycle while rsp_ch does not stall.
//   When rsp_ch stalls, the result register holds its item and the input
//   register can still take one more item; req_ch.ready then drops.
//   The csr_ port is APB-style, registers at byte addresses 0, 4, 8, 12;
//   writes are expected only while no item is in flight.
//   Synchronous reset empties both pipeline registers, clears the controller
//   state and loads the register defaults (target 55, minimum 10, unscaled,
//   period 50).
module fan_speed_deadband_controller_unit import fsdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   fsdc_req_if.sink    req_ch,
   fsdc_rsp_if.source  rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type cfg;
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff, in_item_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff, out_item_in;
   rsp_type core_result;
   logic    advance;
   logic    req_take;

   fsdc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fsdc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (in_item_ff),
      .en     (advance),
      .result (core_result)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_item_in.op         = op_type'(req_ch.op);
      in_item_in.proc_temp  = req_ch.proc_temp;
      in_item_in.board_temp = req_ch.board_temp;
      in_item_in.fan_sense  = req_ch.fan_sense;
      if (req_take)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      else              in_valid_in = in_valid_ff;
      if (advance)           out_valid_in = 1'b1;
      else if (rsp_ch.ready) out_valid_in = 1'b0;
      else                   out_valid_in = out_valid_ff;
      out_item_in = core_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_item_ff  <= in_item_in;
      if (advance)  out_item_ff <= out_item_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.fan_write = out_item_ff.fan_write;
   assign rsp_ch.fan_speed = out_item_ff.fan_speed;
   assign rsp_ch.evaluated = out_item_ff.evaluated;

endmodule

@@ src/fsdc_csr.sv @@
// APB-style configuration registers of the fan controller.
// Depends on fsdc_pkg.
module fsdc_csr import fsdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx        = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_TARGET_TEMP:  cfg_in.target_temp       = csr_pwdata[7:0];
            REG_MIN_FAN:      cfg_in.min_fan_speed     = csr_pwdata[5:0];
            REG_BOARD_SCALED: cfg_in.board_scaled_mode = csr_pwdata[0];
            REG_REFRESH:      cfg_in.refresh_period    = csr_pwdata[5:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_TARGET_TEMP:  csr_prdata = {24'd0, cfg_ff.target_temp};
         REG_MIN_FAN:      csr_prdata = {26'd0, cfg_ff.min_fan_speed};
         REG_BOARD_SCALED: csr_prdata = {31'd0, cfg_ff.board_scaled_mode};
         REG_REFRESH:      csr_prdata = {26'd0, cfg_ff.refresh_period};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_temp       <= 8'd55;
         cfg_ff.min_fan_speed     <= 6'd10;
         cfg_ff.board_scaled_mode <= 1'b0;
         cfg_ff.refresh_period    <= 6'd50;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/fsdc_core.sv @@
// Controller state and the single-pass decision logic for one item.
// Depends on fsdc_pkg.
module fsdc_core import fsdc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  req_type item,
   input  logic    en,
   output rsp_type result
);

   logic [5:0]        tick_count_ff, tick_count_in;
   logic [7:0]        prev_temp_ff, prev_temp_in;
   logic [7:0]        current_fan_ff, current_fan_in;
   logic signed [7:0] hot_persist_ff, hot_persist_in;
   logic signed [7:0] cold_persist_ff, cold_persist_in;

   logic [17:0]       board_prod;
   logic [7:0]        board_eff;
   logic [7:0]        temp;
   logic              eval;
   logic signed [7:0] hot_upd, cold_upd;
   logic signed [9:0] calc, calc_lo, calc_clamped;
   logic [7:0]        new_fan;
   logic              fan_write;

   // board * 4/5, truncated
   assign board_prod = 18'({item.board_temp, 2'b00}) * 18'(DIV5_RECIP);
   assign board_eff  = cfg.board_scaled_mode ? board_prod[DIV5_SHIFT +: 8] : item.board_temp;
   assign temp       = (item.proc_temp > board_eff) ? item.proc_temp : board_eff;
   assign eval       = (item.op == OP_TICK) && (tick_count_ff == cfg.refresh_period);

   always_comb begin
      hot_upd  = hot_persist_ff;
      cold_upd = cold_persist_ff;
      calc     = signed'({2'b00, current_fan_ff});
      if (temp == cfg.target_temp) begin
         hot_upd  = 8'sd0;
         cold_upd = 8'sd0;
         if (temp > prev_temp_ff)      calc = calc + 10'sd1;
         else if (temp < prev_temp_ff) calc = calc - 10'sd1;
      end else if (temp < cfg.target_temp) begin
         if (temp == prev_temp_ff) begin
            if (cold_persist_ff != 8'sd127) cold_upd = cold_persist_ff + 8'sd1;
         end else if (temp > prev_temp_ff) begin
            if (cold_persist_ff != -8'sd128) cold_upd = cold_persist_ff - 8'sd1;
         end
         if ((temp < prev_temp_ff) || (cold_upd == PERSIST_TRIP)) begin
            calc     = calc - 10'sd1;
            cold_upd = 8'sd0;
         end
      end else begin
         if (temp == prev_temp_ff) begin
            if (hot_persist_ff != 8'sd127) hot_upd = hot_persist_ff + 8'sd1;
         end else if (temp < prev_temp_ff) begin
            if (hot_persist_ff != -8'sd128) hot_upd = hot_persist_ff - 8'sd1;
         end
         if ((temp > prev_temp_ff) || (hot_upd == PERSIST_TRIP)) begin
            calc    = calc + 10'sd1;
            hot_upd = 8'sd0;
         end
      end
   end

   // minimum first, then maximum wins when the two cross
   assign calc_lo      = (calc < signed'({4'b0000, cfg.min_fan_speed}))
                         ? signed'({4'b0000, cfg.min_fan_speed}) : calc;
   assign calc_clamped = (calc_lo > signed'({2'b00, MAX_FAN_SPEED}))
                         ? signed'({2'b00, MAX_FAN_SPEED}) : calc_lo;
   assign new_fan      = calc_clamped[7:0];
   assign fan_write    = eval && (new_fan != current_fan_ff);

   always_comb begin
      tick_count_in   = tick_count_ff;
      prev_temp_in    = prev_temp_ff;
      current_fan_in  = current_fan_ff;
      hot_persist_in  = hot_persist_ff;
      cold_persist_in = cold_persist_ff;
      if (item.op == OP_INIT) begin
         current_fan_in = item.fan_sense;
         prev_temp_in   = temp;
      end else if (!eval) begin
         tick_count_in = tick_count_ff + 6'd1;
      end else begin
         tick_count_in   = 6'd0;
         prev_temp_in    = temp;
         current_fan_in  = new_fan;
         hot_persist_in  = hot_upd;
         cold_persist_in = cold_upd;
      end
   end

   assign result.fan_write = fan_write;
   assign result.fan_speed = current_fan_in;
   assign result.evaluated = eval;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff   <= 6'd0;
         prev_temp_ff    <= 8'd0;
         current_fan_ff  <= 8'd0;
         hot_persist_ff  <= 8'sd0;
         cold_persist_ff <= 8'sd0;
      end else if (en) begin
         tick_count_ff   <= tick_count_in;
         prev_temp_ff    <= prev_temp_in;
         current_fan_ff  <= current_fan_in;
         hot_persist_ff  <= hot_persist_in;
         cold_persist_ff <= cold_persist_in;
      end
   end

`ifndef SYNTHESIS
   a_write_needs_eval: assert property (@(posedge clock) disable iff (reset)
      result.fan_write |-> result.evaluated)
      else $error("fan write flagged without an evaluation");

   a_eval_clears_tick: assert property (@(posedge clock) disable iff (reset)
      (en && eval) |=> (tick_count_ff == 6'd0))
      else $error("tick counter not cleared after evaluation");

   a_eval_bounds_fan: assert property (@(posedge clock) disable iff (reset)
      (en && eval) |=> (current_fan_ff <= MAX_FAN_SPEED))
      else $error("evaluated fan speed above maximum");

   a_init_loads_fan: assert property (@(posedge clock) disable iff (reset)
      (en && (item.op == OP_INIT)) |=> (current_fan_ff == $past(item.fan_sense)))
      else $error("init item did not load fan readback");
`endif

endmodule

@@ tb/tb_fan_speed_deadband_controller_unit.sv @@
// Self-checking testbench for fan_speed_deadband_controller_unit: directed table, then random phases.
// Each item is predicted in the bench and every result item is checked in order.
// Depends on fsdc_pkg, fsdc_req_if, fsdc_rsp_if and the unit itself.
module tb_fan_speed_deadband_controller_unit;
   import fsdc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_LIMIT    = 400000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PLAN_ROWS    = 24;
   localparam int NUM_PHASES   = 8;

   typedef enum logic [1:0] {
      SHAPE_WALK,
      SHAPE_RISE,
      SHAPE_FALL
   } shape_type;

   typedef struct packed {
      logic          is_cfg;
      reg_index_type reg_idx;
      logic [7:0]    reg_val;
      req_type       item;
      logic          typed;
      rsp_type       want;
   } plan_row_type;

   typedef struct packed {
      logic [7:0] target;
      logic [5:0] min_speed;
      logic       scaled;
      logic [5:0] period;
      shape_type  shape;
      logic [7:0] count;
      logic       rand_cfg;
   } phase_type;

   localparam req_type Z_ITEM = '{OP_TICK, 8'd0, 8'd0, 8'd0};
   localparam rsp_type NO_RSP = '{1'b0, 8'd0, 1'b0};

   // cfg rows wait for the pipeline to drain before the write
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      '{1'b1, REG_REFRESH, 8'd0, Z_ITEM, 1'b0, NO_RSP},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_TICK, 8'd0, 8'd0, 8'd0}, 1'b1, '{1'b1, 8'd10, 1'b1}},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_INIT, 8'd255, 8'd0, 8'd255}, 1'b1, '{1'b0, 8'd255, 1'b0}},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_TICK, 8'd255, 8'd255, 8'd0}, 1'b1, '{1'b1, 8'd50, 1'b1}},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_TICK, 8'd0, 8'd55, 8'd0}, 1'b0, NO_RSP},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_TICK, 8'd55, 8'd0, 8'd0}, 1'b0, NO_RSP},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_TICK, 8'd56, 8'd0, 8'd0}, 1'b0, NO_RSP},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_TICK, 8'd54, 8'd54, 8'd0}, 1'b0, NO_RSP},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_TICK, 8'd54, 8'd0, 8'd0}, 1'b0, NO_RSP},
      '{1'b1, REG_BOARD_SCALED, 8'd1, Z_ITEM, 1'b0, NO_RSP},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_TICK, 8'd0, 8'd255, 8'd0}, 1'b0, NO_RSP},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_INIT, 8'd10, 8'd70, 8'd0}, 1'b1, '{1'b0, 8'd0, 1'b0}},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_TICK, 8'd0, 8'd69, 8'd0}, 1'b0, NO_RSP},
      '{1'b1, REG_MIN_FAN, 8'd63, Z_ITEM, 1'b0, NO_RSP},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_TICK, 8'd20, 8'd0, 8'd0}, 1'b0, NO_RSP},
      '{1'b1, REG_MIN_FAN, 8'd0, Z_ITEM, 1'b0, NO_RSP},
      '{1'b1, REG_TARGET_TEMP, 8'd0, Z_ITEM, 1'b0, NO_RSP},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_TICK, 8'd0, 8'd0, 8'd0}, 1'b0, NO_RSP},
      '{1'b1, REG_TARGET_TEMP, 8'd255, Z_ITEM, 1'b0, NO_RSP},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_TICK, 8'd255, 8'd255, 8'd0}, 1'b0, NO_RSP},
      '{1'b1, REG_REFRESH, 8'd63, Z_ITEM, 1'b0, NO_RSP},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_TICK, 8'd170, 8'd170, 8'd170}, 1'b0, NO_RSP},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_INIT, 8'd85, 8'd85, 8'd85}, 1'b0, NO_RSP},
      '{1'b0, REG_REFRESH, 8'd0, '{OP_TICK, 8'd0, 8'd0, 8'd0}, 1'b0, NO_RSP}
   };

   // ramps drive the persistence counters into negative saturation
   localparam phase_type PHASES [NUM_PHASES] = '{
      '{8'd255, 6'd0,  1'b0, 6'd0,  SHAPE_RISE, 8'd160, 1'b0},
      '{8'd0,   6'd50, 1'b1, 6'd0,  SHAPE_FALL, 8'd160, 1'b0},
      '{8'd55,  6'd10, 1'b0, 6'd2,  SHAPE_WALK, 8'd120, 1'b0},
      '{8'd40,  6'd25, 1'b1, 6'd1,  SHAPE_WALK, 8'd100, 1'b0},
      '{8'd100, 6'd20, 1'b0, 6'd63, SHAPE_WALK, 8'd130, 1'b0},
      '{8'd70,  6'd0,  1'b1, 6'd1,  SHAPE_WALK, 8'd130, 1'b0},
      '{8'd30,  6'd5,  1'b0, 6'd0,  SHAPE_WALK, 8'd130, 1'b0},
      '{8'd0,   6'd0,  1'b0, 6'd0,  SHAPE_WALK, 8'd120, 1'b1}
   };

   localparam logic [31:0] RESET_REGS [4] = '{32'd55, 32'd10, 32'd0, 32'd50};

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   fsdc_req_if req_ch ();
   fsdc_rsp_if rsp_ch ();

   fan_speed_deadband_controller_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bench copy of the controller
   cfg_type           cfg;
   logic [5:0]        eval_divider;
   logic [7:0]        last_temp;
   logic [7:0]        fan_now;
   logic signed [7:0] hot_streak;
   logic signed [7:0] cold_streak;

   rsp_type fan_results_due [$];
   int      mismatches      = 0;
   int      cycle_count     = 0;
   int      rsp_hold_cycles = 0;
   bit      source_idles    = 1'b1;
   bit      sink_idles      = 1'b1;

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int pick_wait(bit enabled);
      return enabled ? int'($urandom_range(0, 19)) : 0;
   endfunction

   function automatic logic signed [7:0] sat8(int v);
      if (v > 127) return 8'sd127;
      if (v < -128) return -8'sd128;
      return 8'(v);
   endfunction

   // hotter of the two sensors, board optionally scaled by 4/5
   function automatic int hottest_sensor(req_type it);
      int brd;
      brd = cfg.board_scaled_mode ? (int'(it.board_temp) * 4) / 5 : int'(it.board_temp);
      return (int'(it.proc_temp) > brd) ? int'(it.proc_temp) : brd;
   endfunction

   function automatic rsp_type next_fan_result(req_type it);
      rsp_type r;
      int      t;
      int      calc;
      r = '0;
      t = hottest_sensor(it);
      if (it.op == OP_INIT) begin
         fan_now   = it.fan_sense;
         last_temp = 8'(t);
      end else if (eval_divider != cfg.refresh_period) begin
         eval_divider = eval_divider + 6'd1;
      end else begin
         r.evaluated  = 1'b1;
         eval_divider = '0;
         calc         = int'(fan_now);
         if (t == int'(cfg.target_temp)) begin
            hot_streak  = '0;
            cold_streak = '0;
            if (t > int'(last_temp)) calc++;
            else if (t < int'(last_temp)) calc--;
         end else if (t < int'(cfg.target_temp)) begin
            if (t == int'(last_temp)) cold_streak = sat8(int'(cold_streak) + 1);
            else if (t > int'(last_temp)) cold_streak = sat8(int'(cold_streak) - 1);
            if (t < int'(last_temp) || cold_streak == PERSIST_TRIP) begin
               calc--;
               cold_streak = '0;
            end
         end else begin
            if (t == int'(last_temp)) hot_streak = sat8(int'(hot_streak) + 1);
            else if (t < int'(last_temp)) hot_streak = sat8(int'(hot_streak) - 1);
            if (t > int'(last_temp) || hot_streak == PERSIST_TRIP) begin
               calc++;
               hot_streak = '0;
            end
         end
         if (calc < int'(cfg.min_fan_speed)) calc = int'(cfg.min_fan_speed);
         if (calc > int'(MAX_FAN_SPEED)) calc = int'(MAX_FAN_SPEED);
         if (calc != int'(fan_now)) begin
            fan_now     = 8'(calc);
            r.fan_write = 1'b1;
         end
         last_temp = 8'(t);
      end
      r.fan_speed = fan_now;
      return r;
   endfunction

   // sensor pair whose hotter reading is t, carried by either sensor
   function automatic req_type reading_for(op_type op, int t, logic [7:0] readback);
      req_type it;
      it.op        = op;
      it.fan_sense = readback;
      if ($urandom_range(0, 1) == 0 || (cfg.board_scaled_mode && t > 204)) begin
         it.proc_temp  = 8'(t);
         it.board_temp = 8'($urandom_range(0, t));
      end else begin
         it.board_temp = cfg.board_scaled_mode ? 8'((5 * t + 3) / 4) : 8'(t);
         it.proc_temp  = 8'($urandom_range(0, t));
      end
      return it;
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   task automatic send_item(req_type it, logic typed, rsp_type want);
      int      gap;
      rsp_type r;
      gap = pick_wait(source_idles);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.op         <= it.op;
      req_ch.proc_temp  <= it.proc_temp;
      req_ch.board_temp <= it.board_temp;
      req_ch.fan_sense  <= it.fan_sense;
      do @(posedge clock); while (!req_ch.ready);
      r = next_fan_result(it);
      fan_results_due.push_back(typed ? want : r);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (fan_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(reg_index_type idx, logic wr, logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_reg(reg_index_type idx, logic [31:0] val);
      logic [31:0] rd;
      logic [31:0] kept;
      wait_drained();
      csr_access(idx, 1'b1, val, rd);
      case (idx)
         REG_TARGET_TEMP: begin
            cfg.target_temp = val[7:0];
            kept = 32'(cfg.target_temp);
         end
         REG_MIN_FAN: begin
            cfg.min_fan_speed = val[5:0];
            kept = 32'(cfg.min_fan_speed);
         end
         REG_BOARD_SCALED: begin
            cfg.board_scaled_mode = val[0];
            kept = 32'(cfg.board_scaled_mode);
         end
         default: begin
            cfg.refresh_period = val[5:0];
            kept = 32'(cfg.refresh_period);
         end
      endcase
      csr_access(idx, 1'b0, '0, rd);
      flag_mismatch("register readback", kept, rd);
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin : result_sink
      int      stall;
      rsp_type got;
      rsp_type want;
      rsp_ch.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = pick_wait(sink_idles);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got.fan_write = rsp_ch.fan_write;
         got.fan_speed = rsp_ch.fan_speed;
         got.evaluated = rsp_ch.evaluated;
         if (fan_results_due.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected result item, write %0b speed %0d evaluated %0b",
                     $time, got.fan_write, got.fan_speed, got.evaluated);
         end else begin
            want = fan_results_due.pop_front();
            flag_mismatch("fan_write", 32'(want.fan_write), 32'(got.fan_write));
            flag_mismatch("fan_speed", 32'(want.fan_speed), 32'(got.fan_speed));
            flag_mismatch("evaluated", 32'(want.evaluated), 32'(got.evaluated));
         end
      end
   end

   initial begin : stimulus
      phase_type   ph;
      req_type     it;
      int          walk_temp;
      int          hold_left;
      int          pick;
      logic [31:0] rd;

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.op         = OP_TICK;
      req_ch.proc_temp  = '0;
      req_ch.board_temp = '0;
      req_ch.fan_sense  = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      cfg               = '{8'd55, 6'd10, 1'b0, 6'd50};
      eval_divider      = '0;
      last_temp         = '0;
      fan_now           = '0;
      hot_streak        = '0;
      cold_streak       = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 4; i++) begin
         csr_access(reg_index_type'(i), 1'b0, '0, rd);
         flag_mismatch("register reset value", RESET_REGS[i], rd);
      end

      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (DIRECTED_PLAN[i].is_cfg)
            set_reg(DIRECTED_PLAN[i].reg_idx, 32'(DIRECTED_PLAN[i].reg_val));
         else
            send_item(DIRECTED_PLAN[i].item, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         ph = PHASES[p];
         if (ph.rand_cfg) begin
            ph.target    = 8'($urandom_range(0, 255));
            ph.min_speed = 6'($urandom_range(0, 50));
            ph.scaled    = 1'($urandom_range(0, 1));
            ph.period    = 6'($urandom_range(0, 3));
         end
         set_reg(REG_TARGET_TEMP, 32'(ph.target));
         set_reg(REG_MIN_FAN, 32'(ph.min_speed));
         set_reg(REG_BOARD_SCALED, 32'(ph.scaled));
         set_reg(REG_REFRESH, 32'(ph.period));
         source_idles = ($urandom_range(0, 3) != 0);
         sink_idles   = ($urandom_range(0, 3) != 0);
         walk_temp    = int'(ph.target);
         hold_left    = 0;
         for (int k = 0; k < int'(ph.count); k++) begin
            // long result stall while items keep coming: fills the pipeline
            if (p == 2 && k == 10) rsp_hold_cycles = 300;
            if (p == 3 && k == 50) wait_drained();
            case (ph.shape)
               SHAPE_RISE: it = reading_for(OP_TICK, 40 + k, 8'($urandom));
               SHAPE_FALL: it = reading_for(OP_TICK, 215 - k, 8'($urandom));
               default: begin
                  pick = $urandom_range(0, 99);
                  if (pick < 12) begin
                     it.op         = op_type'($urandom_range(0, 1));
                     it.proc_temp  = 8'($urandom);
                     it.board_temp = 8'($urandom);
                     it.fan_sense  = 8'($urandom);
                  end else begin
                     // hold the temperature for a run so the streak counters can trip
                     if (hold_left == 0) begin
                        if ($urandom_range(0, 7) == 0)
                           walk_temp = int'(cfg.target_temp) + int'($urandom_range(0, 6)) - 3;
                        else
                           walk_temp += int'($urandom_range(0, 4)) - 2;
                        if (walk_temp < 0) walk_temp = 0;
                        if (walk_temp > 255) walk_temp = 255;
                        hold_left = $urandom_range(0, 40);
                     end else begin
                        hold_left--;
                     end
                     it = reading_for((pick < 17) ? OP_INIT : OP_TICK, walk_temp, 8'($urandom));
                  end
               end
            endcase
            send_item(it, 1'b0, NO_RSP);
         end
      end

      wait_drained();
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ fan_speed_deadband_controller_unit.f @@
src/fsdc_pkg.sv
src/fsdc_req_if.sv
src/fsdc_rsp_if.sv
src/fsdc_csr.sv
src/fsdc_core.sv
src/fan_speed_deadband_controller_unit.sv
tb/tb_fan_speed_deadband_controller_unit.sv
